// File: rtl/wcorr3_pkg.sv
// ----------------------------------------------------------------------------
// wcorr3_pkg
// Shared widths, register indexes and reset values for the 3x3 window
// correlation block.
// ----------------------------------------------------------------------------
package wcorr3_pkg;

  localparam int PIXEL_W     = 8;
  localparam int COEF_W      = 8;
  localparam int KSIZE       = 3;
  localparam int PROD_W      = PIXEL_W + COEF_W + 1;
  localparam int ROWSUM_W    = PROD_W + 2;
  localparam int SUM_W       = 20;
  localparam int POS_W       = 10;
  localparam int WIDTH_REG_W = 11;
  localparam int KROW_W      = KSIZE * COEF_W;
  localparam int MIN_WIDTH   = 3;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 11'd640;
  localparam logic [POS_W-1:0]       ROW_LIMIT   = 10'd1023;

  // Largest magnitude a window sum can reach: nine times 255 times 128
  localparam int SUM_BOUND = 293760;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH = 2'd0,
    REG_KERNEL_TOP  = 2'd1,
    REG_KERNEL_MID  = 2'd2,
    REG_KERNEL_BOT  = 2'd3
  } cfg_idx_t;

endpackage

// File: rtl/window_correlation_3x3.sv
// ----------------------------------------------------------------------------
// window_correlation_3x3
// Streaming 3x3 correlation over a raster image using one line memory.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per clock once the window
// is full; the pixel that completes a window moves through stages 1 to 4 and the
// output register; the whole pipeline holds while a result waits to be taken. Each
// pixel costs one read and one write of the line memory, which packs both
// previous rows of a column into one entry; the write of one pixel and the read
// of the next fall in the same cycle, and a forwarding path covers the case of
// both hitting the same column (start of frame, width change). Results are
// anchored at the window's top-left pixel and only windows wholly inside the
// image are returned. The line memory needs no clearing after reset.
module window_correlation_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // Pixel stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,    // [7:0] pixel
  input  logic [0:0]                    s_tuser,    // [0] start_of_frame
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,    // [19:0] sum, [29:20] out_row,
                                                    // [39:30] out_col
  // Configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  wcorr3_pkg::cfg_idx_t          cfg_index,
  input  logic [wcorr3_pkg::KROW_W-1:0] cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > wcorr3_pkg::WIDTH_REG_W) ? WW : wcorr3_pkg::WIDTH_REG_W;
  localparam int CXW = CW + wcorr3_pkg::POS_W;
  localparam int LW  = 2 * wcorr3_pkg::PIXEL_W;
  localparam int PW  = wcorr3_pkg::PIXEL_W;
  localparam int PSW = wcorr3_pkg::POS_W;
  localparam int KS  = wcorr3_pkg::KSIZE;

  // Configuration registers
  logic [wcorr3_pkg::WIDTH_REG_W-1:0] image_width;
  logic [wcorr3_pkg::KROW_W-1:0]      kernel [KS];

  // Position counters
  logic [CW-1:0]  col_count, col_next;
  logic [PSW-1:0] row_count, row_next;

  // Accept side
  logic           en, s_acc;
  logic [EW-1:0]  w_eff, w_raw, cn;
  logic [CW-1:0]  c0, c;
  logic [PSW-1:0] r0, r;
  logic           emit;

  // Line memory: high byte is the row two above, low byte the row above
  logic [LW-1:0]  line_mem [MAX_WIDTH];
  logic [LW-1:0]  mem_rd;

  // Stage 1: memory data back
  logic           s1_valid, s1_emit, s1_fwd;
  logic [PW-1:0]  s1_px;
  logic [CW-1:0]  s1_col;
  logic [PSW-1:0] s1_row;
  logic [LW-1:0]  s1_fwd_data, s1_line;
  logic [PW-1:0]  above1, above2;
  logic [CW-1:0]  cm2;
  logic [CXW-1:0] cm2x;

  logic [PW-1:0]  win [KS][KS];

  // Stage 2: window settled
  logic           s2_valid;
  logic [PSW-1:0] s2_row, s2_col;

  // Stage 3: products
  logic                                   s3_valid;
  logic [PSW-1:0]                         s3_row, s3_col;
  logic signed [wcorr3_pkg::PROD_W-1:0]   prod [KS][KS];

  // Stage 4: row sums
  logic                                   s4_valid;
  logic [PSW-1:0]                         s4_row, s4_col;
  logic signed [wcorr3_pkg::ROWSUM_W-1:0] rsum [KS];

  // Output register
  logic signed [wcorr3_pkg::SUM_W-1:0]    out_sum;
  logic [PSW-1:0]                         out_row, out_col;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign s_acc     = s_tvalid && s_tready;
  assign m_tdata   = {out_col, out_row, out_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= wcorr3_pkg::WIDTH_RESET;
      for (int i = 0; i < KS; i++) kernel[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wcorr3_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data[wcorr3_pkg::WIDTH_REG_W-1:0];
        wcorr3_pkg::REG_KERNEL_TOP:  kernel[0] <= cfg_data;
        wcorr3_pkg::REG_KERNEL_MID:  kernel[1] <= cfg_data;
        wcorr3_pkg::REG_KERNEL_BOT:  kernel[2] <= cfg_data;
      endcase
    end
  end

  // Effective width, clamped to the range the line memory supports
  always_comb begin
    w_raw = EW'(image_width);
    if (w_raw < EW'(wcorr3_pkg::MIN_WIDTH)) w_eff = EW'(wcorr3_pkg::MIN_WIDTH);
    else if (w_raw > EW'(MAX_WIDTH))        w_eff = EW'(MAX_WIDTH);
    else                                    w_eff = w_raw;
  end

  // Position of the incoming pixel and of the one after it
  always_comb begin
    c0 = s_tuser[0] ? '0 : col_count;
    r0 = s_tuser[0] ? '0 : row_count;
    // Width lowered mid-row: close the row before placing the pixel
    if (EW'(c0) >= w_eff) begin
      c = '0;
      r = (r0 == wcorr3_pkg::ROW_LIMIT) ? r0 : r0 + PSW'(1);
    end else begin
      c = c0;
      r = r0;
    end
    emit = (r >= PSW'(2)) && (c >= CW'(2));
    cn   = EW'(c) + EW'(1);
    if (cn >= w_eff) begin
      col_next = '0;
      row_next = (r == wcorr3_pkg::ROW_LIMIT) ? r : r + PSW'(1);
    end else begin
      col_next = cn[CW-1:0];
      row_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (s_acc) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

  // Stage 1 line data, forwarded when the previous item wrote the same column
  assign s1_line = s1_fwd ? s1_fwd_data : mem_rd;
  assign above1  = s1_line[PW-1:0];
  assign above2  = s1_line[LW-1:PW];
  assign cm2     = s1_col - CW'(2);
  assign cm2x    = CXW'(cm2);

  always_ff @(posedge clk) begin
    if (en && s1_valid) line_mem[s1_col] <= {above1, s1_px};
    if (s_acc)          mem_rd <= line_mem[c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (en) begin
      s1_valid <= s_acc;
      if (s_acc) s1_fwd <= s1_valid && (s1_col == c);
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_px       <= s_tdata;
      s1_col      <= c;
      s1_row      <= r;
      s1_emit     <= emit;
      s1_fwd_data <= {above1, s1_px};
    end
  end

  // Shift the window left and bring in the new column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KS; i++)
        for (int j = 0; j < KS; j++) win[i][j] <= '0;
    end else if (en && s1_valid) begin
      for (int i = 0; i < KS; i++)
        for (int j = 0; j < KS - 1; j++) win[i][j] <= win[i][j+1];
      win[0][KS-1] <= above2;
      win[1][KS-1] <= above1;
      win[2][KS-1] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      m_tvalid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_row <= s1_row - PSW'(2);
      s2_col <= cm2x[PSW-1:0];
      s3_row <= s2_row;
      s3_col <= s2_col;
      for (int i = 0; i < KS; i++)
        for (int j = 0; j < KS; j++)
          prod[i][j] <= wcorr3_pkg::PROD_W'($signed({1'b0, win[i][j]}))
                      * wcorr3_pkg::PROD_W'($signed(
                          kernel[i][j*wcorr3_pkg::COEF_W +: wcorr3_pkg::COEF_W]));
      s4_row <= s3_row;
      s4_col <= s3_col;
      for (int i = 0; i < KS; i++)
        rsum[i] <= wcorr3_pkg::ROWSUM_W'(prod[i][0])
                 + wcorr3_pkg::ROWSUM_W'(prod[i][1])
                 + wcorr3_pkg::ROWSUM_W'(prod[i][2]);
      out_row <= s4_row;
      out_col <= s4_col;
      out_sum <= wcorr3_pkg::SUM_W'(rsum[0])
               + wcorr3_pkg::SUM_W'(rsum[1])
               + wcorr3_pkg::SUM_W'(rsum[2]);
    end
  end

  // A start-of-frame item lands at the origin
  a_sof_origin: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_tuser[0] |=> s1_col == '0 && s1_row == '0)
    else $error("start of frame not placed at the origin");

  // A completing pixel yields a result slot in the next stage
  a_emit_flow: assert property (@(posedge clk) disable iff (rst)
    en && s1_valid && s1_emit |=> s2_valid)
    else $error("window result dropped");

  // Sum stays within the range a 3x3 window of 8-bit by 8-bit products can reach
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_sum <= wcorr3_pkg::SUM_W'(wcorr3_pkg::SUM_BOUND))
              && (out_sum >= -$signed(wcorr3_pkg::SUM_W'(wcorr3_pkg::SUM_BOUND))))
    else $error("window sum out of range");

endmodule
